@@ rtl/skewed_majority_hit_predictor_unit_macros.svh @@
// Assertion macros used by the predictor unit RTL.
`ifndef SKEWED_MAJORITY_HIT_PREDICTOR_UNIT_MACROS_SVH
`define SKEWED_MAJORITY_HIT_PREDICTOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked while out of reset.
`define SMHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SMHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SMHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SMHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/smhp_pkg.sv @@
package smhp_pkg;

  localparam int INDEX_BITS_DEF   = 10;
  localparam int HISTORY_BITS_DEF = 12;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_RESET = 2'd2;
  localparam ctr_t CTR_MAX   = 2'd3;
  localparam ctr_t CTR_MIN   = 2'd0;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  // Step a saturating counter toward the outcome.
  function automatic ctr_t ctr_train(input ctr_t ctr, input logic hit);
    ctr_t res;
    res = ctr;
    if (hit) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

  // Weakly or strongly taken votes hit.
  function automatic logic ctr_votes_hit(input ctr_t ctr);
    return ctr[1];
  endfunction

endpackage

@@ rtl/smhp_ctr_table.sv @@
module smhp_ctr_table #(
  parameter int INDEX_BITS = smhp_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [INDEX_BITS-1:0] rd_addr,
  output smhp_pkg::ctr_t        rd_data,
  input  logic                  wr_en,
  input  logic [INDEX_BITS-1:0] wr_addr,
  input  smhp_pkg::ctr_t        wr_data
);

  localparam int DEPTH = 1 << INDEX_BITS;

  smhp_pkg::ctr_t mem [DEPTH];
  smhp_pkg::ctr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read returns the old entry on a same-edge write
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/skewed_majority_hit_predictor_unit.sv @@
// Channel   Direction  Ports                                      Word
// in        input      in_valid / in_ready                        in_cmd, in_addr, in_actual_hit
// out       output     out_valid / out_ready                      out_predict_hit
// cfg       input      cfg_wr_en                                  cfg_wr_data (enable)
//
// One word a cycle unless stalled: a word is registered together with the table
// reads, and the next cycle votes (predict) or writes the trained counters back (update).
// The result word is registered once the output register is free; an update gives no result.
// After reset a clearing pass sets every counter to 2 across all 2**INDEX_BITS
// entries (1024 by default), during which in_ready is low.
// A result held in the output register stalls a waiting predict, and in_ready
// then follows out_ready.
`include "skewed_majority_hit_predictor_unit_macros.svh"

module skewed_majority_hit_predictor_unit #(
  parameter int INDEX_BITS   = smhp_pkg::INDEX_BITS_DEF,
  parameter int HISTORY_BITS = smhp_pkg::HISTORY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [63:0] in_addr,
  input  logic        in_actual_hit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_predict_hit,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int NUM_TABLES = 3;

  logic                    enable_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic [HISTORY_BITS-1:0] hist_nxt;
  logic                    clr_r;
  logic [INDEX_BITS-1:0]   clr_idx_r;

  logic                    s_valid_r;
  logic                    s_cmd_r;
  logic                    s_en_r;
  logic                    s_hit_r;
  logic [INDEX_BITS-1:0]   s_idx_r   [NUM_TABLES];
  logic                    byp_r     [NUM_TABLES];
  smhp_pkg::ctr_t          byp_val_r [NUM_TABLES];

  logic                    out_valid_r;
  logic                    out_hit_r;

  logic [63:0]             hist64;
  logic [63:0]             addr5_64;
  logic [INDEX_BITS-1:0]   idx       [NUM_TABLES];
  smhp_pkg::ctr_t          rd_data   [NUM_TABLES];
  smhp_pkg::ctr_t          ctr_eff   [NUM_TABLES];
  smhp_pkg::ctr_t          ctr_new   [NUM_TABLES];
  logic [NUM_TABLES-1:0]   votes;
  logic                    vote_hit;

  logic                    in_acc;
  logic                    s_wr;
  logic                    s_pred;
  logic                    s_leave;
  logic                    out_load;

  logic                    wr_en;
  logic [INDEX_BITS-1:0]   wr_addr   [NUM_TABLES];
  smhp_pkg::ctr_t          wr_data   [NUM_TABLES];

  // index hashes
  assign hist64   = {{(64-HISTORY_BITS){1'b0}}, hist_r};
  assign addr5_64 = {59'd0, in_addr[6:2]};
  assign idx[0]   = in_addr[2 +: INDEX_BITS] ^ hist64[INDEX_BITS-1:0];
  assign idx[1]   = in_addr[12 +: INDEX_BITS] ^ hist64[INDEX_BITS:1];
  assign idx[2]   = in_addr[22 +: INDEX_BITS] ^ hist64[INDEX_BITS-1:0]
                    ^ addr5_64[INDEX_BITS-1:0];

  assign hist_nxt = HISTORY_BITS'({hist_r, in_actual_hit});

  // stage control
  assign s_wr     = s_valid_r && (s_cmd_r == smhp_pkg::CMD_UPDATE) && s_en_r;
  assign s_pred   = s_valid_r && (s_cmd_r == smhp_pkg::CMD_PREDICT);
  assign s_leave  = !s_pred || !out_valid_r || out_ready;
  assign out_load = s_pred && (!out_valid_r || out_ready);
  assign in_ready = !clr_r && (!s_valid_r || s_leave);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      ctr_eff[t] = byp_r[t] ? byp_val_r[t] : rd_data[t];
      ctr_new[t] = smhp_pkg::ctr_train(ctr_eff[t], s_hit_r);
      votes[t]   = smhp_pkg::ctr_votes_hit(ctr_eff[t]);
      wr_addr[t] = clr_r ? clr_idx_r : s_idx_r[t];
      wr_data[t] = clr_r ? smhp_pkg::CTR_RESET : ctr_new[t];
    end
  end

  assign vote_hit = s_en_r && ((votes[0] && votes[1]) || (votes[0] && votes[2])
                               || (votes[1] && votes[2]));
  assign wr_en    = clr_r || s_wr;

  for (genvar g = 0; g < NUM_TABLES; g++) begin : g_tbl
    smhp_ctr_table #(
      .INDEX_BITS(INDEX_BITS)
    ) u_tbl (
      .clk    (clk),
      .rd_en  (in_acc),
      .rd_addr(idx[g]),
      .rd_data(rd_data[g]),
      .wr_en  (wr_en),
      .wr_addr(wr_addr[g]),
      .wr_data(wr_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      hist_r      <= '0;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + INDEX_BITS'(1);
        if (clr_idx_r == '1) clr_r <= 1'b0;
      end
      if (in_acc && (in_cmd == smhp_pkg::CMD_UPDATE) && enable_r) begin
        hist_r <= hist_nxt;
      end
      if (in_acc) begin
        s_valid_r <= 1'b1;
      end else if (s_leave) begin
        s_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: capture word, forward a same-index write from the word ahead
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_cmd_r <= in_cmd;
      s_en_r  <= enable_r;
      s_hit_r <= in_actual_hit;
      for (int t = 0; t < NUM_TABLES; t++) begin
        s_idx_r[t]   <= idx[t];
        byp_r[t]     <= s_wr && (s_idx_r[t] == idx[t]);
        byp_val_r[t] <= ctr_new[t];
      end
    end
    if (out_load) begin
      out_hit_r <= vote_hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_predict_hit = out_hit_r;

  `SMHP_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, clr_r, !in_ready,
                   "word accepted during clearing pass")
  `SMHP_ASSERT_NEXT(a_disabled_predicts_miss, clk, rst_n, out_load && !s_en_r,
                    !out_predict_hit, "disabled predictor voted hit")
  `SMHP_ASSERT_NEXT(a_hist_only_on_update, clk, rst_n,
                    !(in_acc && (in_cmd == smhp_pkg::CMD_UPDATE) && enable_r),
                    $stable(hist_r), "history moved without an enabled update")
  `SMHP_ASSERT_NOW(a_update_no_result, clk, rst_n, s_wr, !out_load,
                   "update word produced a result")

endmodule
